[hdl/itr_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// itr_pkg: shared types and constants for integer_to_radix_string
// Widths, character codes, controller states and the command/status
// bundles that pass between the controller and the datapath.
// ---------------------------------------------------------------------------
package itr_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int RADIX_W     = 6;
  localparam int CHAR_W      = 8;
  localparam int IN_TDATA_W  = ((VALUE_BITS + RADIX_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = CHAR_W;

  // divider retires this many quotient bits per cycle
  localparam int DIV_BPC    = 4;
  localparam int DIV_CYCLES = (VALUE_BITS + DIV_BPC - 1) / DIV_BPC;
  localparam int DIV_W      = DIV_CYCLES * DIV_BPC;
  localparam int STEP_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  // digit stack: up to VALUE_BITS digits (radix 2)
  localparam int SP_W  = $clog2(VALUE_BITS + 1);
  localparam int SP_IW = $clog2(VALUE_BITS);

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_DEC = RADIX_W'(10);

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SIGN,
    S_DIV,
    S_PUSH,
    S_EMIT,
    S_NUL
  } itr_state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic push;
    logic emit_sign;
    logic emit_digit;
    logic emit_nul;
  } itr_cmd_t;

  typedef struct packed {
    logic radix_ok;
    logic neg_dec;
    logic div_last;
    logic quo_zero;
    logic last_digit;
    logic out_free;
  } itr_sts_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dw;
    dw = CHAR_W'(d);
    if (d < RADIX_DEC) begin
      return CHAR_ZERO + dw;
    end
    return CHAR_LA + dw - CHAR_W'(RADIX_DEC);
  endfunction

endpackage

[hdl/itr_dp.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// itr_dp: conversion datapath
// Operand capture, radix divider (several quotient bits a cycle), digit
// stack and the output register.
// ---------------------------------------------------------------------------
module itr_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  itr_pkg::itr_cmd_t                 cmd,
  output itr_pkg::itr_sts_t                 sts,
  input  logic [itr_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [itr_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tlast
);
  import itr_pkg::*;

  logic [VALUE_BITS-1:0] in_value;
  logic [RADIX_W-1:0]    in_radix;
  logic                  in_ok;
  logic                  in_neg;
  logic [VALUE_BITS-1:0] in_mag;

  logic [RADIX_W-1:0]    radix_r;
  logic                  radix_ok_r;
  logic                  neg_dec_r;
  logic [DIV_W-1:0]      dvd_r, dvd_nxt;
  logic [RADIX_W-1:0]    rem_r, rem_nxt;
  logic [STEP_W-1:0]     step_r;
  logic [SP_W-1:0]       sp_r;
  logic [RADIX_W-1:0]    stk [VALUE_BITS];
  logic [SP_W-1:0]       sp_dec;

  logic                  out_valid_r;
  logic [CHAR_W-1:0]     out_data_r;
  logic                  out_last_r;

  assign in_value = in_tdata[VALUE_BITS-1:0];
  assign in_radix = in_tdata[VALUE_BITS +: RADIX_W];
  assign in_ok    = (in_radix >= RADIX_MIN) && (in_radix <= RADIX_MAX);
  assign in_neg   = in_ok && (in_radix == RADIX_DEC) && in_value[VALUE_BITS-1];
  assign in_mag   = in_neg ? (~in_value + VALUE_BITS'(1)) : in_value;
  assign sp_dec   = sp_r - SP_W'(1);

  // restoring division, DIV_BPC bits: dividend shifts out the top,
  // quotient bits shift in at the bottom
  always_comb begin
    logic [DIV_W-1:0]   dv;
    logic [RADIX_W-1:0] rm;
    logic [RADIX_W:0]   t;
    dv = dvd_r;
    rm = rem_r;
    for (int i = 0; i < DIV_BPC; i++) begin
      t = {rm, dv[DIV_W-1]};
      if (t >= {1'b0, radix_r}) begin
        rm = RADIX_W'(t - {1'b0, radix_r});
        dv = {dv[DIV_W-2:0], 1'b1};
      end else begin
        rm = t[RADIX_W-1:0];
        dv = {dv[DIV_W-2:0], 1'b0};
      end
    end
    dvd_nxt = dv;
    rem_nxt = rm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
      radix_ok_r  <= 1'b0;
      neg_dec_r   <= 1'b0;
    end else begin
      if (cmd.load) begin
        radix_ok_r <= in_ok;
        neg_dec_r  <= in_neg;
        step_r     <= '0;
        sp_r       <= '0;
      end else if (cmd.div_step) begin
        step_r <= step_r + STEP_W'(1);
      end else if (cmd.push) begin
        step_r <= '0;
        sp_r   <= sp_r + SP_W'(1);
      end else if (cmd.emit_digit) begin
        sp_r <= sp_dec;
      end
      if (cmd.emit_sign || cmd.emit_digit || cmd.emit_nul) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      radix_r <= in_radix;
      dvd_r   <= DIV_W'(in_mag);
      rem_r   <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end else if (cmd.push) begin
      rem_r <= '0;
    end
    if (cmd.push) begin
      stk[sp_r[SP_IW-1:0]] <= rem_r;
    end
    if (cmd.emit_sign) begin
      out_data_r <= CHAR_MINUS;
      out_last_r <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_data_r <= digit_char(stk[sp_dec[SP_IW-1:0]]);
      out_last_r <= 1'b0;
    end else if (cmd.emit_nul) begin
      out_data_r <= CHAR_NUL;
      out_last_r <= 1'b1;
    end
  end

  assign sts.radix_ok   = radix_ok_r;
  assign sts.neg_dec    = neg_dec_r;
  assign sts.div_last   = (step_r == STEP_W'(DIV_CYCLES - 1));
  assign sts.quo_zero   = (dvd_r == '0);
  assign sts.last_digit = (sp_r == SP_W'(1));
  assign sts.out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

[hdl/itr_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// itr_ctrl: conversion sequencer
// Steps one item through sign, digit division, digit pushes and the
// emission of the text run, stalling on the output register.
// ---------------------------------------------------------------------------
module itr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  itr_pkg::itr_sts_t sts,
  output itr_pkg::itr_cmd_t cmd
);
  import itr_pkg::*;

  itr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        // refuse beats while reset is held
        in_tready = rst_n;
        if (in_tvalid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = S_SIGN;
        end
      end
      S_SIGN: begin
        priority if (!sts.radix_ok) begin
          state_nxt = S_NUL;
        end else if (!sts.neg_dec) begin
          state_nxt = S_DIV;
        end else if (sts.out_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          // hold until the output register frees
          state_nxt = S_SIGN;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        // dividend register now holds the quotient
        cmd.push  = 1'b1;
        state_nxt = sts.quo_zero ? S_EMIT : S_DIV;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_digit = 1'b1;
          if (sts.last_digit) begin
            state_nxt = S_NUL;
          end
        end
      end
      S_NUL: begin
        if (sts.out_free) begin
          cmd.emit_nul = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[hdl/integer_to_radix_string.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// integer_to_radix_string: signed integer to ASCII text in radix 2..36
// One input beat gives a run of character beats, most significant digit
// first, closed by a NUL beat with tlast set.
// ---------------------------------------------------------------------------
// Takes one item at a time. Digits come from repeated division by the
// radix in a shared divider that retires 4 quotient bits a cycle; each
// digit is a full pass of divide steps followed by a push onto the digit
// stack. An item is converted in order (accept, sign, digits; a '-' goes
// out in the sign state once the output register is free), then its
// digits and the closing NUL are emitted, stalling on out_tready.
// A new item is accepted once the NUL beat sits in the output register.
// Radix 10 prints negatives with '-'; other radices print the 32-bit two's
// complement pattern; an invalid radix gives just the NUL.
module integer_to_radix_string (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [itr_pkg::IN_TDATA_W-1:0]      in_tdata,   // value[31:0], radix[37:32]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [itr_pkg::OUT_TDATA_W-1:0]     out_tdata,  // character[7:0]
  output logic                                out_tlast
);
  import itr_pkg::*;

  itr_cmd_t cmd;
  itr_sts_t sts;

  itr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  itr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for integer_to_radix_string
// Sends signed values with radices from 0 to 63 and compares every returned
// character beat, and its tlast flag, with text predicted in the bench.
// A short directed set covers zero, the extremes, negatives, letter digits
// and invalid radices. Random items follow in four phases: no idling, an
// idle sender, a stalling receiver, and light idling on both sides.
// ---------------------------------------------------------------------------
module tb;
  import itr_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS  = 48;

  localparam logic [VALUE_BITS-1:0] INT_LO = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [VALUE_BITS-1:0] INT_HI = ~INT_LO;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_beat_t;

  // Holds the text still owed by the block, oldest character first.
  class radix_text_board;
    text_beat_t pending_chars[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    // Spell one accepted value in its radix and queue the characters.
    function void note_value(logic [VALUE_BITS-1:0] value, logic [RADIX_W-1:0] radix);
      logic [VALUE_BITS-1:0] mag;
      logic [VALUE_BITS-1:0] rad;
      logic [VALUE_BITS-1:0] d;
      logic [CHAR_W-1:0]     digits[$];
      if (radix >= RADIX_MIN && radix <= RADIX_MAX) begin
        mag = value;
        rad = VALUE_BITS'(radix);
        if (radix == RADIX_DEC && value[VALUE_BITS-1]) begin
          pending_chars.push_back('{CHAR_MINUS, 1'b0});
          // unsigned negate: the most negative value keeps its magnitude
          mag = -value;
        end
        do begin
          d = mag % rad;
          if (d < VALUE_BITS'(RADIX_DEC)) begin
            digits.push_front(CHAR_ZERO + CHAR_W'(d));
          end else begin
            digits.push_front(CHAR_LA + CHAR_W'(d) - CHAR_W'(RADIX_DEC));
          end
          mag = mag / rad;
        end while (mag != '0);
        foreach (digits[i]) begin
          pending_chars.push_back('{digits[i], 1'b0});
        end
      end
      pending_chars.push_back('{CHAR_NUL, 1'b1});
    endfunction

    function void check_char(logic [CHAR_W-1:0] ch, logic last);
      text_beat_t want;
      if (pending_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual char %h last %b",
                 $time, ch, last);
        return;
      end
      want = pending_chars.pop_front();
      if (want.ch !== ch) begin
        errors++;
        $display("%0t: char mismatch, expected %h, actual %h", $time, want.ch, ch);
      end
      if (want.last !== last) begin
        errors++;
        $display("%0t: tlast mismatch, expected %b, actual %b", $time, want.last, last);
      end
    endfunction
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // value[31:0], radix[37:32]
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // character[7:0]
  logic                   out_tlast;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;

  radix_text_board board = new();

  integer_to_radix_string u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      board.note_value(in_tdata[VALUE_BITS-1:0], in_tdata[VALUE_BITS +: RADIX_W]);
    end
    if (rst_n && out_tvalid && out_tready) begin
      board.check_char(out_tdata, out_tlast);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one value; hold valid across back-to-back beats.
  task automatic send_value(input logic [VALUE_BITS-1:0] value,
                            input logic [RADIX_W-1:0] radix);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= IN_TDATA_W'({$urandom, $urandom});
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({radix, value});
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [VALUE_BITS-1:0] pick_value();
    case ($urandom_range(6))
      0: return VALUE_BITS'($urandom_range(40));
      1: return -VALUE_BITS'($urandom_range(1000));
      2: begin
        case ($urandom_range(3))
          0: return INT_LO;
          1: return INT_HI;
          2: return '1;
          default: return VALUE_BITS'(1);
        endcase
      end
      3: return VALUE_BITS'($signed(16'($urandom)));
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [RADIX_W-1:0] pick_radix();
    case ($urandom_range(9))
      0, 1: return RADIX_DEC;
      2: begin
        if ($urandom_range(1)) begin
          return RADIX_W'($urandom_range(1));
        end
        return RADIX_W'($urandom_range(63, 37));
      end
      3: return $urandom_range(1) ? RADIX_MIN : RADIX_MAX;
      default: return RADIX_W'($urandom_range(RADIX_MAX, RADIX_MIN));
    endcase
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_value('0, RADIX_DEC);
    send_value('0, RADIX_MIN);
    send_value('0, RADIX_MAX);
    send_value(VALUE_BITS'(1), RADIX_DEC);
    send_value('1, RADIX_DEC);
    send_value('1, RADIX_MIN);
    send_value('1, RADIX_W'(16));
    send_value(INT_LO, RADIX_DEC);
    send_value(INT_LO, RADIX_MIN);
    send_value(INT_LO, RADIX_W'(16));
    send_value(INT_HI, RADIX_DEC);
    send_value(INT_HI, RADIX_MIN);
    send_value(INT_HI, RADIX_MAX);
    send_value(VALUE_BITS'(35), RADIX_MAX);
    send_value(VALUE_BITS'(32'hdeadbeef), RADIX_W'(16));
    send_value(VALUE_BITS'(-123456789), RADIX_DEC);
    send_value(VALUE_BITS'(-8), RADIX_W'(8));
    send_value(VALUE_BITS'(12345), RADIX_W'(3));
    send_value(VALUE_BITS'(1000), RADIX_W'(7));
    send_value(VALUE_BITS'(42), RADIX_W'(0));
    send_value(INT_LO, RADIX_W'(1));
    send_value('1, RADIX_W'(37));
    send_value(INT_HI, RADIX_W'(63));

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      repeat (PHASE_ITEMS) send_value(pick_value(), pick_radix());
    end
    in_tvalid <= 1'b0;

    while (board.pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.errors == 0 && board.pending_chars.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
